>>> sv/s2l_pkg.sv
// ----------------------------------------------------------------------------
// s2l_pkg
// constants and year tables for the solar to lunar date converter
// ----------------------------------------------------------------------------
package s2l_pkg;

    localparam int BaseYear   = 1997;
    localparam int TableYears = 203;
    localparam int IdxW       = 8;
    localparam int MonthSteps = 13;

    localparam logic [11:0] YearMin = 12'(BaseYear + 3);
    localparam logic [11:0] YearMax = 12'(BaseYear + TableYears - 1);

    localparam logic [16:0] MONTH_BITS [TableYears] = '{
        17'h0B26D, 17'h0125C, 17'h0192C, 17'h09A95, 17'h01A94, 17'h01B4A, 17'h04B55, 17'h00AD4,
        17'h0F55B, 17'h004BA, 17'h0125A, 17'h0B92B, 17'h0152A, 17'h01694, 17'h096AA, 17'h015AA,
        17'h12AB5, 17'h00974, 17'h014B6, 17'h0CA57, 17'h00A56, 17'h01526, 17'h08E95, 17'h00D54,
        17'h015AA, 17'h049B5, 17'h0096C, 17'h0D4AE, 17'h0149C, 17'h01A4C, 17'h0BD26, 17'h01AA6,
        17'h00B54, 17'h06D6A, 17'h012DA, 17'h1695D, 17'h0095A, 17'h0149A, 17'h0DA4B, 17'h01A4A,
        17'h01AA4, 17'h0BB54, 17'h016B4, 17'h00ADA, 17'h0495B, 17'h00936, 17'h0F497, 17'h01496,
        17'h0154A, 17'h0B6A5, 17'h00DA4, 17'h015B4, 17'h06AB6, 17'h0126E, 17'h1092F, 17'h0092E,
        17'h00C96, 17'h0CD4A, 17'h01D4A, 17'h00D64, 17'h0956C, 17'h0155C, 17'h0125C, 17'h0792E,
        17'h0192C, 17'h0FA95, 17'h01A94, 17'h01B4A, 17'h0AB55, 17'h00AD4, 17'h014DA, 17'h08A5D,
        17'h00A5A, 17'h1152B, 17'h0152A, 17'h01694, 17'h0D6AA, 17'h015AA, 17'h00AB4, 17'h094BA,
        17'h014B6, 17'h00A56, 17'h07527, 17'h00D26, 17'h0EE53, 17'h00D54, 17'h015AA, 17'h0A9B5,
        17'h0096C, 17'h014AE, 17'h08A4E, 17'h01A4C, 17'h11D26, 17'h01AA4, 17'h01B54, 17'h0CD6A,
        17'h00ADA, 17'h0095C, 17'h0949D, 17'h0149A, 17'h01A2A, 17'h05B25, 17'h01AA4, 17'h0FB52,
        17'h016B4, 17'h00ABA, 17'h0A95B, 17'h00936, 17'h01496, 17'h09A4B, 17'h0154A, 17'h136A5,
        17'h00DA4, 17'h015AC, 17'h0CAB6, 17'h0126E, 17'h0092E, 17'h08C97, 17'h00A96, 17'h00D4A,
        17'h06DA5, 17'h00D54, 17'h0F56A, 17'h0155A, 17'h00A5C, 17'h0B92E, 17'h0152C, 17'h01A94,
        17'h09D4A, 17'h01B2A, 17'h16B55, 17'h00AD4, 17'h014DA, 17'h0CA5D, 17'h00A5A, 17'h0151A,
        17'h0BA95, 17'h01654, 17'h016AA, 17'h04AD5, 17'h00AB4, 17'h0F4BA, 17'h014B6, 17'h00A56,
        17'h0B517, 17'h00D16, 17'h00E52, 17'h096AA, 17'h00D6A, 17'h165B5, 17'h0096C, 17'h014AE,
        17'h0CA2E, 17'h01A2C, 17'h01D16, 17'h0AD52, 17'h01B52, 17'h00B6A, 17'h0656D, 17'h0055C,
        17'h0F45D, 17'h0145A, 17'h01A2A, 17'h0DA95, 17'h016A4, 17'h01AD2, 17'h08B5A, 17'h00AB6,
        17'h1455B, 17'h008B6, 17'h01456, 17'h0D52B, 17'h0152A, 17'h01694, 17'h0B6AA, 17'h015AA,
        17'h00AB6, 17'h064B7, 17'h008AE, 17'h0EC57, 17'h00A56, 17'h00D2A, 17'h0CD95, 17'h00B54,
        17'h0156A, 17'h08A6D, 17'h0095C, 17'h014AE, 17'h04A56, 17'h01A54, 17'h0DD2A, 17'h01AAA,
        17'h00B54, 17'h0B56A, 17'h014DA, 17'h0095C, 17'h074AB, 17'h0149A, 17'h0FA4B, 17'h01652,
        17'h016AA, 17'h0CAD5, 17'h005B4};

    localparam logic [20:0] NEW_YEAR [TableYears] = '{
        21'h0F9C3C, 21'h0F9E50, 21'h0FA045, 21'h0FA238, 21'h0FA44C, 21'h0FA641, 21'h0FA836,
        21'h0FAA49, 21'h0FAC3D, 21'h0FAE52, 21'h0FB047, 21'h0FB23A, 21'h0FB44E, 21'h0FB643,
        21'h0FB837, 21'h0FBA4A, 21'h0FBC3F, 21'h0FBE53, 21'h0FC048, 21'h0FC23C, 21'h0FC450,
        21'h0FC645, 21'h0FC839, 21'h0FCA4C, 21'h0FCC41, 21'h0FCE36, 21'h0FD04A, 21'h0FD23D,
        21'h0FD451, 21'h0FD646, 21'h0FD83A, 21'h0FDA4D, 21'h0FDC43, 21'h0FDE37, 21'h0FE04B,
        21'h0FE23F, 21'h0FE453, 21'h0FE648, 21'h0FE83C, 21'h0FEA4F, 21'h0FEC44, 21'h0FEE38,
        21'h0FF04C, 21'h0FF241, 21'h0FF436, 21'h0FF64A, 21'h0FF83E, 21'h0FFA51, 21'h0FFC46,
        21'h0FFE3A, 21'h10004E, 21'h100242, 21'h100437, 21'h10064B, 21'h100841, 21'h100A53,
        21'h100C48, 21'h100E3C, 21'h10104F, 21'h101244, 21'h101438, 21'h10164C, 21'h101842,
        21'h101A35, 21'h101C49, 21'h101E3D, 21'h102051, 21'h102245, 21'h10243A, 21'h10264E,
        21'h102843, 21'h102A37, 21'h102C4B, 21'h102E3F, 21'h103053, 21'h103247, 21'h10343B,
        21'h10364F, 21'h103845, 21'h103A38, 21'h103C4C, 21'h103E42, 21'h104036, 21'h104249,
        21'h10443D, 21'h104651, 21'h104846, 21'h104A3A, 21'h104C4E, 21'h104E43, 21'h105038,
        21'h10524A, 21'h10543E, 21'h105652, 21'h105847, 21'h105A3B, 21'h105C4F, 21'h105E45,
        21'h106039, 21'h10624C, 21'h106441, 21'h106635, 21'h106849, 21'h106A3D, 21'h106C51,
        21'h106E47, 21'h10703C, 21'h10724F, 21'h107444, 21'h107638, 21'h10784C, 21'h107A3F,
        21'h107C53, 21'h107E48, 21'h10803D, 21'h108250, 21'h108446, 21'h10863A, 21'h10884E,
        21'h108A42, 21'h108C36, 21'h108E4A, 21'h10903E, 21'h109251, 21'h109447, 21'h10963B,
        21'h10984F, 21'h109A43, 21'h109C37, 21'h109E4B, 21'h10A041, 21'h10A253, 21'h10A448,
        21'h10A63D, 21'h10A851, 21'h10AA45, 21'h10AC39, 21'h10AE4D, 21'h10B042, 21'h10B236,
        21'h10B44A, 21'h10B63E, 21'h10B852, 21'h10BA47, 21'h10BC3B, 21'h10BE4F, 21'h10C044,
        21'h10C237, 21'h10C44B, 21'h10C641, 21'h10C854, 21'h10CA48, 21'h10CC3D, 21'h10CE50,
        21'h10D045, 21'h10D239, 21'h10D44C, 21'h10D642, 21'h10D837, 21'h10DA4A, 21'h10DC3E,
        21'h10DE52, 21'h10E047, 21'h10E23A, 21'h10E44E, 21'h10E643, 21'h10E838, 21'h10EA4B,
        21'h10EC41, 21'h10EE54, 21'h10F049, 21'h10F23C, 21'h10F450, 21'h10F645, 21'h10F839,
        21'h10FA4C, 21'h10FC42, 21'h10FE37, 21'h11004B, 21'h11023E, 21'h110452, 21'h110647,
        21'h11083B, 21'h110A4E, 21'h110C43, 21'h110E38, 21'h11104C, 21'h11123F, 21'h111435,
        21'h111648, 21'h11183C, 21'h111A4F, 21'h111C45, 21'h111E39, 21'h11204D, 21'h112242,
        21'h112436, 21'h11264A, 21'h11283E, 21'h112A51, 21'h112C46, 21'h112E3B, 21'h11304F};

    // day offset of a march-based month, (ms*306+5)/10
    function automatic logic [8:0] month_offset(input logic [3:0] ms);
        logic [8:0] r;
        case (ms)
            4'd0:    r = 9'd0;
            4'd1:    r = 9'd31;
            4'd2:    r = 9'd61;
            4'd3:    r = 9'd92;
            4'd4:    r = 9'd122;
            4'd5:    r = 9'd153;
            4'd6:    r = 9'd184;
            4'd7:    r = 9'd214;
            4'd8:    r = 9'd245;
            4'd9:    r = 9'd275;
            4'd10:   r = 9'd306;
            default: r = 9'd337;
        endcase
        return r;
    endfunction

endpackage

>>> sv/solar_to_lunar_date.sv
// ----------------------------------------------------------------------------
// solar_to_lunar_date
// converts a gregorian date to a chinese lunar date from per-year tables
// ----------------------------------------------------------------------------
// channel  dir  fields (lsb first)
// s_axis   in   tdata: greg_year[11:0], greg_month[15:12], greg_day[20:16]
// m_axis   out  tdata: lunar_year[11:0], lunar_month[15:12], lunar_day[20:16],
//               leap_flag[21]
// one word passes from acceptance to result through a table lookup, two
// day-number passes through one shared adder (four steps each), thirteen month
// steps through the same subtract and compare unit and one leap adjustment.
// an invalid date gives its result in the cycle after acceptance. the input is not
// ready while a word is in work or its result waits; m_axis_tvalid holds until taken.
// reset is asynchronous, active low, and clears the sequencer only.
// ----------------------------------------------------------------------------
module solar_to_lunar_date (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // greg_year, greg_month, greg_day
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata   // lunar_year, lunar_month, lunar_day, leap_flag
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_LOOK = 6'b000010,
        ST_DAYN = 6'b000100,
        ST_WALK = 6'b001000,
        ST_LEAP = 6'b010000,
        ST_OUT  = 6'b100000
    } state_t;

    state_t state_reg, state_next;

    logic [11:0] yr_reg;
    logic [3:0]  mo_reg;
    logic [4:0]  dy_reg;
    logic [7:0]  idx_reg;
    logic [16:0] bits_reg;
    logic [20:0] ny_reg;
    logic [3:0]  step_reg;
    logic [19:0] acc_reg;
    logic [19:0] dn_reg;
    logic [15:0] count_reg;
    logic [3:0]  lm_reg;
    logic        walk_done_reg;
    logic [11:0] o_year_reg;
    logic [3:0]  o_month_reg;
    logic [4:0]  o_day_reg;
    logic        o_flag_reg;

    logic [11:0] in_yr;
    logic [3:0]  in_mo;
    logic [4:0]  in_dy;
    logic        in_ok;
    logic [7:0]  idx0;
    logic [20:0] packed_in;

    assign in_yr = s_axis_tdata[11:0];
    assign in_mo = s_axis_tdata[15:12];
    assign in_dy = s_axis_tdata[20:16];
    assign in_ok = (in_mo >= 4'd1) && (in_mo <= 4'd12) && (in_dy != 5'd0)
                   && (in_yr >= s2l_pkg::YearMin) && (in_yr <= s2l_pkg::YearMax);
    assign idx0 = 8'(in_yr - 12'(s2l_pkg::BaseYear + 1));
    assign packed_in = {in_yr, in_mo, in_dy};

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_OUT);
    assign m_axis_tdata  = {2'b00, o_flag_reg, o_day_reg, o_month_reg, o_year_reg};

    // day-number operands; step 0..3 of pass one use the input date, 4..7 the new year
    logic [11:0] d_y;
    logic [3:0]  d_m;
    logic [4:0]  d_d;
    logic [3:0]  d_ms;
    logic [11:0] d_ys;
    logic [22:0] d_prod;
    logic [5:0]  d_q100;
    logic [19:0] term;
    logic        d_sub;

    always_comb
    begin
        if (step_reg[2])
        begin
            d_y = ny_reg[20:9];
            d_m = ny_reg[8:5];
            d_d = ny_reg[4:0];
        end
        else
        begin
            d_y = yr_reg;
            d_m = mo_reg;
            d_d = dy_reg;
        end
        d_ms = (d_m >= 4'd3) ? d_m - 4'd3 : d_m + 4'd9;
        d_ys = (d_ms >= 4'd10) ? d_y - 12'd1 : d_y;
        // ys/100 by reciprocal multiply, exact for any 12-bit year
        d_prod = 23'(d_ys) * 23'd1311;
        d_q100 = d_prod[22:17];
        d_sub = 1'b0;
        case (step_reg[1:0])
            2'd0:    term = 20'(d_ys) * 20'd365;
            2'd1:    term = 20'(d_ys >> 2);
            2'd2:
            begin
                term  = 20'(d_q100);
                d_sub = 1'b1;
            end
            default: term = 20'(d_q100[5:2]) + 20'(s2l_pkg::month_offset(d_ms))
                            + 20'(d_d) - 20'd1;
        endcase
    end

    // shared subtract and compare unit of the month walk
    logic [4:0]  dm;
    logic [15:0] count_sub;
    logic        take;
    logic [16:0] bits_sh;

    assign bits_sh   = bits_reg >> (4'd12 - step_reg);
    assign dm        = bits_sh[0] ? 5'd30 : 5'd29;
    assign count_sub = count_reg - 16'(dm);
    assign take      = !walk_done_reg && (count_reg > 16'(dm));

    logic [3:0] leap;
    assign leap = bits_reg[16:13];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_axis_tvalid) state_next = in_ok ? ST_LOOK : ST_OUT;
            ST_LOOK: state_next = ST_DAYN;
            ST_DAYN: if (step_reg == 4'd7) state_next = ST_WALK;
            ST_WALK: if (step_reg == 4'(s2l_pkg::MonthSteps - 1)) state_next = ST_LEAP;
            ST_LEAP: state_next = ST_OUT;
            ST_OUT:  if (m_axis_tready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                yr_reg   <= in_yr;
                mo_reg   <= in_mo;
                dy_reg   <= in_dy;
                step_reg <= 4'd0;
                acc_reg  <= 20'd0;
                // previous year's entry when the date is before new year
                if (idx0 < 8'(s2l_pkg::TableYears) && s2l_pkg::NEW_YEAR[idx0] > packed_in)
                    idx_reg <= idx0 - 8'd1;
                else
                    idx_reg <= idx0;
                o_year_reg  <= 12'd0;
                o_month_reg <= 4'd0;
                o_day_reg   <= 5'd0;
                o_flag_reg  <= 1'b0;
            end
            ST_LOOK:
            begin
                ny_reg   <= s2l_pkg::NEW_YEAR[idx_reg];
                bits_reg <= s2l_pkg::MONTH_BITS[idx_reg];
            end
            ST_DAYN:
            begin
                if (step_reg == 4'd3)
                begin
                    dn_reg  <= acc_reg + term;
                    acc_reg <= 20'd0;
                end
                else if (d_sub)
                    acc_reg <= acc_reg - term;
                else
                    acc_reg <= acc_reg + term;
                if (step_reg == 4'd7)
                begin
                    count_reg     <= 16'(dn_reg - (acc_reg + term)) + 16'd1;
                    step_reg      <= 4'd0;
                    lm_reg        <= 4'd1;
                    walk_done_reg <= 1'b0;
                end
                else
                    step_reg <= step_reg + 4'd1;
            end
            ST_WALK:
            begin
                if (take)
                begin
                    count_reg <= count_sub;
                    lm_reg    <= lm_reg + 4'd1;
                end
                else
                    walk_done_reg <= 1'b1;
                step_reg <= step_reg + 4'd1;
            end
            ST_LEAP:
            begin
                o_year_reg <= 12'(16'(idx_reg) + 16'(s2l_pkg::BaseYear + 1));
                o_day_reg  <= count_reg[4:0];
                if (leap != 4'd0 && lm_reg > leap)
                begin
                    o_month_reg <= lm_reg - 4'd1;
                    o_flag_reg  <= (lm_reg == leap + 4'd1);
                end
                else
                begin
                    o_month_reg <= lm_reg;
                    o_flag_reg  <= 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !s_axis_tready)
        else $error("input ready while busy");
    a_bad_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && !in_ok) |=> (m_axis_tvalid && m_axis_tdata == 24'd0))
        else $error("invalid date not zeroed");
    a_month_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && o_year_reg != 12'd0) |-> (o_month_reg >= 4'd1 && o_month_reg <= 4'd13))
        else $error("lunar month out of range");
    a_walk_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WALK) |-> (step_reg < 4'(s2l_pkg::MonthSteps)))
        else $error("month walk overran");

endmodule
